>>> rtl/core/tpag_pkg.sv
// tpag_pkg: shared types, constants and helpers for the tensor permute
// address generator (front counters, request queue, address pipeline).
// No dependencies.
package tpag_pkg;

   localparam int DIM_BITS    = 8;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 32;
   localparam int SIZE_BITS   = 9;
   localparam int PERM_BITS   = 2;
   localparam int NUM_DIMS    = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // effective extent must hold both a raw size value and 1 << DIM_BITS
   localparam int EXT_BITS = (SIZE_BITS > DIM_BITS + 1) ? SIZE_BITS : DIM_BITS + 1;
   localparam logic [EXT_BITS-1:0] EXT_CAP = EXT_BITS'(1) << DIM_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SIZE_D0 = 3'd0,
      CSR_SIZE_D1 = 3'd1,
      CSR_SIZE_D2 = 3'd2,
      CSR_SIZE_D3 = 3'd3,
      CSR_PERM_0  = 3'd4,
      CSR_PERM_1  = 3'd5,
      CSR_PERM_2  = 3'd6,
      CSR_PERM_3  = 3'd7
   } csr_index_type;

   typedef logic [NUM_DIMS-1:0][DIM_BITS-1:0]  coord_vec_type;
   typedef logic [NUM_DIMS-1:0][EXT_BITS-1:0]  ext_vec_type;
   typedef logic [NUM_DIMS-1:0][PERM_BITS-1:0] perm_vec_type;

   typedef struct packed {
      ext_vec_type  ext;
      perm_vec_type perm;
   } cfg_type;

   typedef struct packed {
      coord_vec_type          coords;
      logic [DATA_BITS-1:0]   element;
      logic                   last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic at_origin;
   } front_stat_type;

   // zero acts as one, anything above the counter range is capped
   function automatic logic [EXT_BITS-1:0] eff_extent(input logic [SIZE_BITS-1:0] size);
      logic [EXT_BITS-1:0] wide;
      wide = EXT_BITS'(size);
      if (wide == '0) begin
         return EXT_BITS'(1);
      end else if (wide > EXT_CAP) begin
         return EXT_CAP;
      end
      return wide;
   endfunction

endpackage

>>> rtl/core/tpag_req_if.sv
// tpag_req_if: request channel carrying source-order element words.
// Depends on tpag_pkg.
interface tpag_req_if;
   logic                           valid;
   logic                           ready;
   logic [tpag_pkg::DATA_BITS-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

>>> rtl/core/tpag_rsp_if.sv
// tpag_rsp_if: response channel carrying destination address and element.
// Depends on tpag_pkg.
interface tpag_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tpag_pkg::ADDR_BITS-1:0] dest_addr;
   logic [tpag_pkg::DATA_BITS-1:0] element_out;
   logic                           last;

   modport source (output valid, output dest_addr, output element_out, output last,
                   input ready);
   modport sink   (input valid, input dest_addr, input element_out, input last,
                   output ready);
endinterface

>>> rtl/core/tpag_front.sv
// tpag_front: accepts requests, runs the source coordinate odometer and
// tags each element with its coordinates and last flag. Depends on tpag_pkg.
module tpag_front (
   input  logic                     clock,
   input  logic                     reset,
   input  tpag_pkg::cfg_type        cfg,
   tpag_req_if.sink                 req,
   input  tpag_pkg::queue_stat_type q_stat,
   output logic                     push,
   output tpag_pkg::entry_type      push_data,
   output tpag_pkg::front_stat_type f_stat
);

   tpag_pkg::coord_vec_type        coords_ff;
   tpag_pkg::coord_vec_type        coords_in;
   logic [tpag_pkg::NUM_DIMS-1:0]  at_end;
   logic [tpag_pkg::NUM_DIMS:0]    carry;
   logic [tpag_pkg::EXT_BITS-1:0]  next_pos [tpag_pkg::NUM_DIMS];

   assign req.ready = !q_stat.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      for (int i = 0; i < tpag_pkg::NUM_DIMS; i++) begin
         next_pos[i] = tpag_pkg::EXT_BITS'(coords_ff[i]) + tpag_pkg::EXT_BITS'(1);
         // a counter past its extent also counts as at its end
         at_end[i]   = next_pos[i] >= cfg.ext[i];
      end
      // innermost dimension is the highest index
      carry[tpag_pkg::NUM_DIMS] = 1'b1;
      for (int i = tpag_pkg::NUM_DIMS - 1; i >= 0; i--) begin
         carry[i] = carry[i+1] && at_end[i];
         if (!carry[i+1]) begin
            coords_in[i] = coords_ff[i];
         end else if (at_end[i]) begin
            coords_in[i] = '0;
         end else begin
            coords_in[i] = next_pos[i][tpag_pkg::DIM_BITS-1:0];
         end
      end
   end

   assign push_data.coords  = coords_ff;
   assign push_data.element = req.element;
   assign push_data.last    = &at_end;
   assign f_stat.at_origin  = (coords_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         coords_ff <= '0;
      end else if (push) begin
         coords_ff <= coords_in;
      end
   end

endmodule

>>> rtl/core/tpag_queue.sv
// tpag_queue: short register queue between the front and the address
// pipeline so each side stalls on its own. Depends on tpag_pkg.
module tpag_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tpag_pkg::entry_type      push_data,
   input  logic                     pop,
   output tpag_pkg::entry_type      head,
   output tpag_pkg::queue_stat_type q_stat
);

   tpag_pkg::entry_type             slot_ff [tpag_pkg::QUEUE_DEPTH];
   logic [tpag_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tpag_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [tpag_pkg::QCNT_BITS-1:0]  count_ff, count_in;

   localparam logic [tpag_pkg::QPTR_BITS-1:0] LAST_PTR =
      tpag_pkg::QPTR_BITS'(tpag_pkg::QUEUE_DEPTH - 1);
   localparam logic [tpag_pkg::QCNT_BITS-1:0] FULL_CNT =
      tpag_pkg::QCNT_BITS'(tpag_pkg::QUEUE_DEPTH);

   assign q_stat.full  = (count_ff == FULL_CNT);
   assign q_stat.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/tpag_back.sv
// tpag_back: three-stage address pipeline, one multiply-add per stage,
// last stage is the response register. Depends on tpag_pkg, tpag_rsp_if.
module tpag_back (
   input  logic                     clock,
   input  logic                     reset,
   input  tpag_pkg::cfg_type        cfg,
   input  tpag_pkg::queue_stat_type q_stat,
   input  tpag_pkg::entry_type      head,
   output logic                     pop,
   tpag_rsp_if.source               rsp
);

   localparam int AB = tpag_pkg::ADDR_BITS;

   logic en1, en2, en3;

   logic                           v1_ff, v2_ff, v3_ff;
   logic [AB-1:0]                  a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic [tpag_pkg::DIM_BITS-1:0]  o2_s1_ff, o3_s1_ff, o3_s2_ff;
   logic [tpag_pkg::DATA_BITS-1:0] el1_ff, el2_ff, el3_ff;
   logic                           l1_ff, l2_ff, l3_ff;

   // stages collapse bubbles: each moves when the one after it has room
   assign en3 = !v3_ff || rsp.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign pop = !q_stat.empty && en1;

   assign a1_in = AB'(head.coords[cfg.perm[0]]) * AB'(cfg.ext[cfg.perm[1]])
                + AB'(head.coords[cfg.perm[1]]);
   assign a2_in = a1_ff * AB'(cfg.ext[cfg.perm[2]]) + AB'(o2_s1_ff);
   assign a3_in = a2_ff * AB'(cfg.ext[cfg.perm[3]]) + AB'(o3_s2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= pop;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         a1_ff    <= a1_in;
         o2_s1_ff <= head.coords[cfg.perm[2]];
         o3_s1_ff <= head.coords[cfg.perm[3]];
         el1_ff   <= head.element;
         l1_ff    <= head.last;
      end
      if (en2) begin
         a2_ff    <= a2_in;
         o3_s2_ff <= o3_s1_ff;
         el2_ff   <= el1_ff;
         l2_ff    <= l1_ff;
      end
      if (en3) begin
         a3_ff    <= a3_in;
         el3_ff   <= el2_ff;
         l3_ff    <= l2_ff;
      end
   end

   assign rsp.valid       = v3_ff;
   assign rsp.dest_addr   = a3_ff;
   assign rsp.element_out = el3_ff;
   assign rsp.last        = l3_ff;

endmodule

>>> rtl/core/tensor_permute_address_generator.sv
// Tensor permute address generator: source-order element stream in,
// (destination address, element, last) out for a permuted 4D tensor.
//
// Channels: req_bus takes one element word per request in source row-major
// order; rsp_bus returns one response per request, in order, with the flat
// row-major address in the permuted tensor and a last flag on the final
// element, after which the coordinate counters start again at zero.
// csr_* writes the four source extents and the four permutation entries;
// write only while no request is in flight.
// Throughput: one request per cycle sustained while rsp_bus is ready.
// An accepted request passes through its queue slot and then the three
// multiply-add stages of the address pipeline, in that order, before it
// is valid on rsp_bus.
// Stalls: a two-entry queue sits between the counter front end and the
// address pipeline; req_bus.ready drops only when that queue is full, so a
// stalled receiver backs up the pipeline first and the front end later.
// Reset: synchronous; counters at zero, queue and pipeline empty, extents
// one and permutation identity.
module tensor_permute_address_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   tpag_req_if.sink                               req_bus,
   tpag_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_en,
   input  logic [tpag_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tpag_pkg::SIZE_BITS-1:0]         csr_wdata
);

   logic [tpag_pkg::SIZE_BITS-1:0]  size_ff [tpag_pkg::NUM_DIMS];
   tpag_pkg::perm_vec_type          perm_ff;
   tpag_pkg::cfg_type               cfg;

   logic                            push;
   logic                            pop;
   tpag_pkg::entry_type             push_data;
   tpag_pkg::entry_type             head;
   tpag_pkg::queue_stat_type        q_stat;
   tpag_pkg::front_stat_type        f_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tpag_pkg::NUM_DIMS; i++) begin
            size_ff[i] <= tpag_pkg::SIZE_BITS'(1);
            perm_ff[i] <= tpag_pkg::PERM_BITS'(i);
         end
      end else if (csr_write_en) begin
         case (tpag_pkg::csr_index_type'(csr_index))
            tpag_pkg::CSR_SIZE_D0: size_ff[0] <= csr_wdata;
            tpag_pkg::CSR_SIZE_D1: size_ff[1] <= csr_wdata;
            tpag_pkg::CSR_SIZE_D2: size_ff[2] <= csr_wdata;
            tpag_pkg::CSR_SIZE_D3: size_ff[3] <= csr_wdata;
            tpag_pkg::CSR_PERM_0:  perm_ff[0] <= csr_wdata[tpag_pkg::PERM_BITS-1:0];
            tpag_pkg::CSR_PERM_1:  perm_ff[1] <= csr_wdata[tpag_pkg::PERM_BITS-1:0];
            tpag_pkg::CSR_PERM_2:  perm_ff[2] <= csr_wdata[tpag_pkg::PERM_BITS-1:0];
            tpag_pkg::CSR_PERM_3:  perm_ff[3] <= csr_wdata[tpag_pkg::PERM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < tpag_pkg::NUM_DIMS; i++) begin
         cfg.ext[i] = tpag_pkg::eff_extent(size_ff[i]);
      end
      cfg.perm = perm_ff;
   end

   tpag_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_bus),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data),
      .f_stat    (f_stat)
   );

   tpag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   tpag_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .q_stat (q_stat),
      .head   (head),
      .pop    (pop),
      .rsp    (rsp_bus)
   );

`ifndef SYNTHESIS
   // final element wraps every counter back to the origin
   assert property (@(posedge clock) disable iff (reset)
      (push && push_data.last) |=> f_stat.at_origin)
      else $error("counters did not wrap after last element");

   // a full queue with nothing drained stays full
   assert property (@(posedge clock) disable iff (reset)
      (q_stat.full && !pop) |=> q_stat.full)
      else $error("queue lost an entry while stalled");

   // reset leaves no response pending and an empty queue
   assert property (@(posedge clock)
      reset |=> (!rsp_bus.valid && q_stat.empty))
      else $error("state not cleared by reset");
`endif

endmodule
